// File: src/dtrie_pkg.sv
package dtrie_pkg;

  // Default sizes of the node pool, the key alphabet and the stored value.
  localparam int NODE_COUNT_DEF = 1024;
  localparam int BRANCHES_DEF   = 10;
  localparam int VALUE_BITS_DEF = 16;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  // Read and write enables from the walk controller to the node store.
  typedef struct packed {
    logic mask_rd;
    logic mask_wr;
    logic ptr_rd;
    logic ptr_wr;
    logic ev_rd;
    logic ev_wr;
  } dtrie_mem_cmd_t;

endpackage

// File: src/dtrie_store.sv
module dtrie_store
  import dtrie_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int BRANCHES   = BRANCHES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(NODE_COUNT),
  localparam int SLOT_W    = $clog2(NODE_COUNT * BRANCHES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtrie_mem_cmd_t        cmd,
  input  logic [IDX_W-1:0]      mask_addr,
  input  logic [BRANCHES-1:0]   mask_wdata,
  input  logic [SLOT_W-1:0]     slot_addr,
  input  logic [IDX_W-1:0]      ptr_wdata,
  input  logic [IDX_W-1:0]      ev_addr,
  input  logic                  ev_wend,
  input  logic [VALUE_BITS-1:0] ev_wvalue,
  output logic [BRANCHES-1:0]   mask_rdata,
  output logic [IDX_W-1:0]      ptr_rdata,
  output logic                  end_rdata,
  output logic [VALUE_BITS-1:0] value_rdata
);

  // Child masks per node, child pointers per slot, end flag and value per node.
  logic [BRANCHES-1:0]   mask_mem [NODE_COUNT];
  logic [IDX_W-1:0]      ptr_mem  [NODE_COUNT * BRANCHES];
  logic [VALUE_BITS:0]   ev_mem   [NODE_COUNT];

  logic [BRANCHES-1:0]   mask_q;
  logic [IDX_W-1:0]      ptr_q;
  logic [VALUE_BITS:0]   ev_q;
  logic                  mask_root_blank;
  logic                  ev_root_blank;
  logic                  root_mask_ok;
  logic                  root_ev_ok;

  // The root's mask and end flag read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_mask_ok <= 1'b0;
      root_ev_ok   <= 1'b0;
    end else begin
      if (cmd.mask_wr && (mask_addr == '0)) begin
        root_mask_ok <= 1'b1;
      end
      if (cmd.ev_wr && (ev_addr == '0)) begin
        root_ev_ok <= 1'b1;
      end
    end
  end

  // Child mask memory.
  always_ff @(posedge clk) begin
    if (cmd.mask_wr) begin
      mask_mem[mask_addr] <= mask_wdata;
    end
    if (cmd.mask_rd) begin
      mask_q          <= mask_mem[mask_addr];
      mask_root_blank <= (mask_addr == '0) && !root_mask_ok;
    end
  end

  // Child pointer memory.
  always_ff @(posedge clk) begin
    if (cmd.ptr_wr) begin
      ptr_mem[slot_addr] <= ptr_wdata;
    end
    if (cmd.ptr_rd) begin
      ptr_q <= ptr_mem[slot_addr];
    end
  end

  // End flag and value memory.
  always_ff @(posedge clk) begin
    if (cmd.ev_wr) begin
      ev_mem[ev_addr] <= {ev_wend, ev_wvalue};
    end
    if (cmd.ev_rd) begin
      ev_q          <= ev_mem[ev_addr];
      ev_root_blank <= (ev_addr == '0) && !root_ev_ok;
    end
  end

  assign mask_rdata  = mask_root_blank ? '0 : mask_q;
  assign ptr_rdata   = ptr_q;
  assign end_rdata   = ev_root_blank ? 1'b0 : ev_q[VALUE_BITS];
  assign value_rdata = ev_q[VALUE_BITS-1:0];

endmodule

// File: src/dtrie_ctrl.sv
module dtrie_ctrl
  import dtrie_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int BRANCHES   = BRANCHES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(NODE_COUNT),
  localparam int SLOT_W    = $clog2(NODE_COUNT * BRANCHES),
  localparam int USED_W    = $clog2(NODE_COUNT + 1),
  localparam int BR_W      = $clog2(BRANCHES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  operation,
  input  logic                  has_digit,
  input  logic [3:0]            digit,
  input  logic                  key_end,
  input  logic [15:0]           stored_value,
  output logic                  busy,
  output logic                  done,
  output logic [1:0]            status,
  output logic [15:0]           found_value,
  output dtrie_mem_cmd_t        cmd,
  output logic [IDX_W-1:0]      mask_addr,
  output logic [BRANCHES-1:0]   mask_wdata,
  output logic [SLOT_W-1:0]     slot_addr,
  output logic [IDX_W-1:0]      ptr_wdata,
  output logic [IDX_W-1:0]      ev_addr,
  output logic                  ev_wend,
  output logic [VALUE_BITS-1:0] ev_wvalue,
  input  logic [BRANCHES-1:0]   mask_rdata,
  input  logic [IDX_W-1:0]      ptr_rdata,
  input  logic                  end_rdata,
  input  logic [VALUE_BITS-1:0] value_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]            state, state_next;
  logic [IDX_W-1:0]      cursor, cursor_next;
  logic [USED_W-1:0]     nodes_used, nodes_used_next;
  logic                  walk_stopped, walk_stopped_next;
  logic                  insert_failed, insert_failed_next;
  logic                  op_q, op_q_next;
  logic                  end_q, end_q_next;
  logic [VALUE_BITS-1:0] val_q, val_q_next;
  logic [BR_W-1:0]       dig_q, dig_q_next;
  logic [SLOT_W-1:0]     slot_q, slot_q_next;
  logic [IDX_W-1:0]      fresh_q, fresh_q_next;
  logic                  done_next;
  logic [1:0]            status_next;
  logic [VALUE_BITS-1:0] found_q, found_next;

  logic [VALUE_BITS-1:0] val_in;
  logic                  digit_ok;
  logic                  step;
  logic [SLOT_W-1:0]     in_slot;
  logic [IDX_W-1:0]      fresh;
  logic                  pool_full;
  logic                  fin_req;
  logic                  fin_op;
  logic                  fin_stop;
  logic                  fin_fail;
  logic [IDX_W-1:0]      fin_node;
  logic [VALUE_BITS-1:0] fin_val;

  assign val_in    = VALUE_BITS'(stored_value);
  assign digit_ok  = ({1'b0, digit} < 5'(BRANCHES));
  assign step      = has_digit && digit_ok && !walk_stopped && !insert_failed;
  assign in_slot   = SLOT_W'(cursor) * SLOT_W'(BRANCHES) + SLOT_W'(digit);
  assign fresh     = nodes_used[IDX_W-1:0];
  assign pool_full = (nodes_used >= USED_W'(NODE_COUNT));

  assign busy        = (state != S_IDLE);
  assign found_value = 16'(found_q);

  // Walk sequencer: read the node's mask and the child slot together, then
  // follow, stop, fail on a full pool or allocate. A final beat writes the end
  // node, reads it back for a lookup, or reports a failed insert.
  always_comb begin
    state_next         = state;
    cursor_next        = cursor;
    nodes_used_next    = nodes_used;
    walk_stopped_next  = walk_stopped;
    insert_failed_next = insert_failed;
    op_q_next          = op_q;
    end_q_next         = end_q;
    val_q_next         = val_q;
    dig_q_next         = dig_q;
    slot_q_next        = slot_q;
    fresh_q_next       = fresh_q;
    done_next          = 1'b0;
    status_next        = ST_OK;
    found_next         = '0;
    cmd                = '0;
    mask_addr          = cursor;
    mask_wdata         = mask_rdata | (BRANCHES'(1) << dig_q);
    slot_addr          = slot_q;
    ptr_wdata          = fresh;
    ev_addr            = cursor;
    ev_wend            = 1'b0;
    ev_wvalue          = '0;
    fin_req            = 1'b0;
    fin_op             = op_q;
    fin_stop           = walk_stopped;
    fin_fail           = insert_failed;
    fin_node           = cursor;
    fin_val            = val_q;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_q_next  = operation;
          end_q_next = key_end;
          val_q_next = val_in;
          dig_q_next = BR_W'(digit);
          if (step) begin
            cmd.mask_rd = 1'b1;
            cmd.ptr_rd  = 1'b1;
            slot_addr   = in_slot;
            slot_q_next = in_slot;
            state_next  = S_WALK;
          end else if (key_end) begin
            fin_req = 1'b1;
            fin_op  = operation;
            fin_val = val_in;
          end
        end
      end
      S_WALK: begin
        state_next = S_IDLE;
        if (mask_rdata[dig_q]) begin
          // Child exists: follow it.
          cursor_next = ptr_rdata;
          fin_node    = ptr_rdata;
          fin_req     = end_q;
        end else if (!op_q) begin
          walk_stopped_next = 1'b1;
          fin_stop          = 1'b1;
          fin_req           = end_q;
        end else if (pool_full) begin
          insert_failed_next = 1'b1;
          fin_fail           = 1'b1;
          fin_req            = end_q;
        end else begin
          // Allocate a fresh node and link it under the cursor.
          cmd.mask_wr     = 1'b1;
          cmd.ptr_wr      = 1'b1;
          cmd.ev_wr       = 1'b1;
          ev_addr         = fresh;
          nodes_used_next = nodes_used + USED_W'(1);
          cursor_next     = fresh;
          fresh_q_next    = fresh;
          state_next      = S_CLEAR;
          if (end_q) begin
            // A fresh node is never an end before this beat.
            done_next          = 1'b1;
            cursor_next        = '0;
            walk_stopped_next  = 1'b0;
            insert_failed_next = 1'b0;
            if (op_q) begin
              ev_wend   = 1'b1;
              ev_wvalue = val_q;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
        end
      end
      S_CLEAR: begin
        // Give the fresh node an empty child mask.
        cmd.mask_wr = 1'b1;
        mask_addr   = fresh_q;
        mask_wdata  = '0;
        state_next  = S_IDLE;
      end
      S_FIN: begin
        done_next   = 1'b1;
        status_next = end_rdata ? ST_OK : ST_NOT_FOUND;
        found_next  = end_rdata ? value_rdata : '0;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Close the key at the node reached.
    if (fin_req) begin
      cursor_next        = '0;
      walk_stopped_next  = 1'b0;
      insert_failed_next = 1'b0;
      ev_addr            = fin_node;
      if (fin_op) begin
        done_next = 1'b1;
        if (fin_fail) begin
          status_next = ST_POOL_FULL;
        end else if (fin_stop) begin
          status_next = ST_NOT_FOUND;
        end else begin
          cmd.ev_wr = 1'b1;
          ev_wend   = 1'b1;
          ev_wvalue = fin_val;
        end
      end else begin
        cmd.ev_rd  = 1'b1;
        state_next = S_FIN;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cursor        <= '0;
      nodes_used    <= USED_W'(1);
      walk_stopped  <= 1'b0;
      insert_failed <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      cursor        <= cursor_next;
      nodes_used    <= nodes_used_next;
      walk_stopped  <= walk_stopped_next;
      insert_failed <= insert_failed_next;
      done          <= done_next;
    end
  end

  // Beat and result payload.
  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    end_q   <= end_q_next;
    val_q   <= val_q_next;
    dig_q   <= dig_q_next;
    slot_q  <= slot_q_next;
    fresh_q <= fresh_q_next;
    status  <= status_next;
    found_q <= found_next;
  end

endmodule

// File: src/digit_trie_insert_lookup.sv
// A digit beat does one memory read of mask and child pointer, then the
// step, and then a clear of the new node's mask when it allocates one; a final
// lookup adds one read of the end node, and the result strobe is registered.
// A new beat is taken only while idle: start is ignored while busy is high.
// Reset: empty trie with only the root allocated, cursor at the root.
// The receiver cannot stall: done is high for exactly one cycle per result.
module digit_trie_insert_lookup
  import dtrie_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int BRANCHES   = BRANCHES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic        has_digit,
  input  logic [3:0]  digit,
  input  logic        key_end,
  input  logic [15:0] stored_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] found_value
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int SLOT_W = $clog2(NODE_COUNT * BRANCHES);

  dtrie_mem_cmd_t        cmd;
  logic [IDX_W-1:0]      mask_addr;
  logic [BRANCHES-1:0]   mask_wdata;
  logic [SLOT_W-1:0]     slot_addr;
  logic [IDX_W-1:0]      ptr_wdata;
  logic [IDX_W-1:0]      ev_addr;
  logic                  ev_wend;
  logic [VALUE_BITS-1:0] ev_wvalue;
  logic [BRANCHES-1:0]   mask_rdata;
  logic [IDX_W-1:0]      ptr_rdata;
  logic                  end_rdata;
  logic [VALUE_BITS-1:0] value_rdata;

  // Walk sequencer.
  dtrie_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .BRANCHES   (BRANCHES),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .has_digit    (has_digit),
    .digit        (digit),
    .key_end      (key_end),
    .stored_value (stored_value),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .found_value  (found_value),
    .cmd          (cmd),
    .mask_addr    (mask_addr),
    .mask_wdata   (mask_wdata),
    .slot_addr    (slot_addr),
    .ptr_wdata    (ptr_wdata),
    .ev_addr      (ev_addr),
    .ev_wend      (ev_wend),
    .ev_wvalue    (ev_wvalue),
    .mask_rdata   (mask_rdata),
    .ptr_rdata    (ptr_rdata),
    .end_rdata    (end_rdata),
    .value_rdata  (value_rdata)
  );

  // Node pool memories.
  dtrie_store #(
    .NODE_COUNT (NODE_COUNT),
    .BRANCHES   (BRANCHES),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mask_addr   (mask_addr),
    .mask_wdata  (mask_wdata),
    .slot_addr   (slot_addr),
    .ptr_wdata   (ptr_wdata),
    .ev_addr     (ev_addr),
    .ev_wend     (ev_wend),
    .ev_wvalue   (ev_wvalue),
    .mask_rdata  (mask_rdata),
    .ptr_rdata   (ptr_rdata),
    .end_rdata   (end_rdata),
    .value_rdata (value_rdata)
  );

endmodule
